@@ design/lrbc_pkg.sv @@
// Shared types and constants of the register binding cache.
`timescale 1ns / 1ps

package lrbc_pkg;

  // Fixed field widths.
  localparam int CmdW   = 2;
  localparam int VarW   = 10;
  localparam int RegW   = 5;
  localparam int StampW = 32;
  localparam int MaskW  = 32;

  // Registers 8 to 25 may be allocated after reset.
  localparam logic [MaskW-1:0] UsableReset = 32'h03FF_FF00;

  // Request codes.
  typedef enum logic [CmdW-1:0] {
    CMD_BIND    = 2'd0,
    CMD_TEMP    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  // What a register currently holds.
  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_VAR  = 2'd1,
    KIND_TEMP = 2'd2
  } kind_e;

  // Request sequencer states; the map is cleared once after reset.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_HITCHK,
    ST_PICK,
    ST_SEARCH,
    ST_VICTIM,
    ST_RELEASE,
    ST_CLEAR
  } state_e;

endpackage

@@ design/lrbc_victim_search.sv @@
// Stamp memory and the sweep that finds the least recently used register.
`timescale 1ns / 1ps

module lrbc_victim_search #(
  parameter int NUM_REGS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [NUM_REGS-1:0]          usable_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(NUM_REGS)-1:0]  wr_idx_i,
  input  logic [lrbc_pkg::StampW-1:0]  wr_stamp_i,
  output logic                         done_o,
  output logic [$clog2(NUM_REGS)-1:0]  best_idx_o
);

  localparam int IdxW = $clog2(NUM_REGS);
  localparam int CntW = $clog2(NUM_REGS + 1);

  logic [lrbc_pkg::StampW-1:0] stamp_mem [NUM_REGS];
  logic [lrbc_pkg::StampW-1:0] rd_q;
  logic [lrbc_pkg::StampW-1:0] best_stamp_q;
  logic [IdxW-1:0]             best_idx_q;
  logic [IdxW-1:0]             cmp_idx_q;
  logic [CntW-1:0]             issue_q;
  logic                        active_q;
  logic                        cmp_vld_q;
  logic                        best_vld_q;
  logic                        done_q;
  logic                        issuing;
  logic                        better;

  assign issuing = active_q && (issue_q < CntW'(NUM_REGS));
  assign better  = cmp_vld_q && usable_i[cmp_idx_q] &&
                   (!best_vld_q || (rd_q < best_stamp_q));

  // Stamp memory: one write port for the sequencer, one read port for the sweep.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      stamp_mem[wr_idx_i] <= wr_stamp_i;
    end
    rd_q <= stamp_mem[issue_q[IdxW-1:0]];
  end

  // Sweep control: one read issued and one stamp compared each cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      cmp_vld_q  <= 1'b0;
      best_vld_q <= 1'b0;
      done_q     <= 1'b0;
      issue_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        active_q   <= 1'b1;
        cmp_vld_q  <= 1'b0;
        best_vld_q <= 1'b0;
        issue_q    <= '0;
      end else if (active_q) begin
        cmp_vld_q <= issuing;
        if (issuing) begin
          issue_q <= issue_q + CntW'(1);
        end
        if (better) begin
          best_vld_q <= 1'b1;
        end
        if (!issuing && cmp_vld_q) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // Running minimum; a strict compare keeps the lowest index on a tie.
  always_ff @(posedge clk_i) begin
    if (issuing) begin
      cmp_idx_q <= issue_q[IdxW-1:0];
    end
    if (active_q && better) begin
      best_idx_q   <= cmp_idx_q;
      best_stamp_q <= rd_q;
    end
  end

  assign done_o     = done_q;
  assign best_idx_o = best_idx_q;

endmodule

@@ design/lru_register_binding_cache_unit.sv @@
// Top level of the register binding cache with least recently used replacement.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle, marked by done_o, and cannot be
// held off. An unknown code or a variable out of range is answered from the
// idle state without leaving it. A release passes through the release state;
// a temporary goes to the pick state and ends there if it finds a free
// register. A bind passes through the lookup and hit check states, ends there
// on a hit and goes on to the pick state otherwise. When every usable register
// is occupied the stamps are swept one per cycle through a single memory read
// port before the victim state. The variable map lookup and the owner read each
// go through a registered memory read. After reset, busy stays high while a
// clearing pass writes every variable map entry once. usable_mask may be written
// only while busy is low and no result is pending.
module lru_register_binding_cache_unit #(
  parameter int NUM_REGS = 32,
  parameter int NUM_VARS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cfg_we_i,
  input  logic [lrbc_pkg::MaskW-1:0]  cfg_wdata_i,
  input  logic [lrbc_pkg::CmdW-1:0]   command_i,
  input  logic [lrbc_pkg::VarW-1:0]   var_index_i,
  input  logic                        load_flag_i,
  input  logic [lrbc_pkg::RegW-1:0]   release_reg_i,
  output logic                        done_o,
  output logic [lrbc_pkg::RegW-1:0]   granted_reg_o,
  output logic                        spill_valid_o,
  output logic [lrbc_pkg::VarW-1:0]   spilled_var_o,
  output logic                        fill_valid_o,
  output logic                        no_register_o
);

  // Registers above 31 are never usable, and variables above 1023 never arrive.
  localparam int NumRegsEff = (NUM_REGS < 32) ? NUM_REGS : 32;
  localparam int NumVarsEff = (NUM_VARS < 1024) ? NUM_VARS : 1024;
  localparam int RegIdxW    = $clog2(NumRegsEff);
  localparam int VarIdxW    = $clog2(NumVarsEff);
  localparam int VarW       = lrbc_pkg::VarW;
  localparam int RegW       = lrbc_pkg::RegW;

  lrbc_pkg::state_e state_q, state_d;

  logic [lrbc_pkg::MaskW-1:0]  usable_q;
  logic [lrbc_pkg::StampW-1:0] counter_q;
  lrbc_pkg::kind_e             kind_q [NumRegsEff];

  logic [lrbc_pkg::CmdW-1:0] cmd_q;
  logic [VarW-1:0]           var_q;
  logic                      load_q;
  logic [RegW-1:0]           rel_q;

  logic [RegIdxW-1:0] map_mem [NumVarsEff];
  logic [RegIdxW-1:0] map_rd_q;
  logic [VarW-1:0]    owner_mem [NumRegsEff];
  logic [VarW-1:0]    owner_rd_q;
  logic [VarIdxW-1:0] clr_q;

  logic            done_q;
  logic [RegW-1:0] granted_q;
  logic            spill_q;
  logic [VarW-1:0] spilled_var_q;
  logic            fill_q;
  logic            none_q;

  logic [NumRegsEff-1:0] usable;
  logic                  accept;
  logic                  var_in_range;
  logic                  hit;
  logic                  rel_ok;
  logic                  usable_any;
  logic                  free_found;
  logic [RegIdxW-1:0]    free_idx;
  logic                  is_bind;
  lrbc_pkg::kind_e       alloc_kind;
  logic                  search_done;
  logic [RegIdxW-1:0]    best_idx;
  logic                  clearing;
  logic                  clr_last;

  logic               search_go;
  logic [RegIdxW-1:0] owner_raddr;
  logic               commit_en;
  logic [RegIdxW-1:0] commit_idx;
  lrbc_pkg::kind_e    commit_kind;
  logic               rel_clear;
  logic               res_load;
  logic [RegW-1:0]    res_granted;
  logic               res_spill;
  logic [VarW-1:0]    res_var;
  logic               res_fill;
  logic               res_none;

  assign usable       = usable_q[NumRegsEff-1:0];
  assign usable_any   = |usable;
  assign busy         = (state_q != lrbc_pkg::ST_IDLE);
  assign accept       = start && !busy;
  assign var_in_range = {1'b0, var_index_i} < (VarW + 1)'(NumVarsEff);
  assign rel_ok       = {1'b0, rel_q} < (RegW + 1)'(NumRegsEff);
  assign is_bind      = (cmd_q == lrbc_pkg::CMD_BIND);
  assign alloc_kind   = is_bind ? lrbc_pkg::KIND_VAR : lrbc_pkg::KIND_TEMP;
  assign clearing     = (state_q == lrbc_pkg::ST_CLEAR);
  assign clr_last     = (clr_q == VarIdxW'(NumVarsEff - 1));

  // A variable is bound exactly when the register its map entry names still
  // holds it, so stale map entries need no clearing once every entry has
  // been given a defined register by the pass after reset.
  assign hit = ({1'b0, map_rd_q} < (RegIdxW + 1)'(NumRegsEff)) &&
               (kind_q[map_rd_q] == lrbc_pkg::KIND_VAR) &&
               (owner_rd_q == var_q);

  // Lowest numbered usable register that is free.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int r = NumRegsEff - 1; r >= 0; r--) begin
      if (usable[r] && (kind_q[r] == lrbc_pkg::KIND_FREE)) begin
        free_found = 1'b1;
        free_idx   = RegIdxW'(r);
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q <= lrbc_pkg::UsableReset;
    end else if (cfg_we_i) begin
      usable_q <= cfg_wdata_i;
    end
  end

  // Sequencer state; the block starts by clearing the variable map.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrbc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Map entry counter of the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + VarIdxW'(1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lrbc_pkg::ST_IDLE: begin
        if (accept) begin
          case (command_i)
            lrbc_pkg::CMD_BIND:    state_d = var_in_range ? lrbc_pkg::ST_LOOKUP
                                                          : lrbc_pkg::ST_IDLE;
            lrbc_pkg::CMD_TEMP:    state_d = lrbc_pkg::ST_PICK;
            lrbc_pkg::CMD_RELEASE: state_d = lrbc_pkg::ST_RELEASE;
            default:               state_d = lrbc_pkg::ST_IDLE;
          endcase
        end
      end
      lrbc_pkg::ST_LOOKUP: state_d = lrbc_pkg::ST_HITCHK;
      lrbc_pkg::ST_HITCHK: state_d = hit ? lrbc_pkg::ST_IDLE : lrbc_pkg::ST_PICK;
      lrbc_pkg::ST_PICK: begin
        state_d = (!usable_any || free_found) ? lrbc_pkg::ST_IDLE
                                              : lrbc_pkg::ST_SEARCH;
      end
      lrbc_pkg::ST_SEARCH: begin
        if (search_done) begin
          state_d = lrbc_pkg::ST_VICTIM;
        end
      end
      lrbc_pkg::ST_VICTIM:  state_d = lrbc_pkg::ST_IDLE;
      lrbc_pkg::ST_RELEASE: state_d = lrbc_pkg::ST_IDLE;
      lrbc_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = lrbc_pkg::ST_IDLE;
        end
      end
      default:              state_d = lrbc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: memory addresses, the commit of an allocation, results.
  always_comb begin
    search_go   = 1'b0;
    owner_raddr = release_reg_i[RegIdxW-1:0];
    commit_en   = 1'b0;
    commit_idx  = free_idx;
    commit_kind = alloc_kind;
    rel_clear   = 1'b0;
    res_load    = 1'b0;
    res_granted = '0;
    res_spill   = 1'b0;
    res_var     = '0;
    res_fill    = 1'b0;
    res_none    = 1'b0;
    case (state_q)
      lrbc_pkg::ST_IDLE: begin
        if (accept) begin
          case (command_i)
            lrbc_pkg::CMD_BIND: begin
              res_load = !var_in_range;
              res_none = 1'b1;
            end
            lrbc_pkg::CMD_TEMP, lrbc_pkg::CMD_RELEASE: res_load = 1'b0;
            default: res_load = 1'b1;
          endcase
        end
      end
      lrbc_pkg::ST_LOOKUP: owner_raddr = map_rd_q;
      lrbc_pkg::ST_HITCHK: begin
        // A hit rewrites the same binding and refreshes only the stamp.
        if (hit) begin
          commit_en   = 1'b1;
          commit_idx  = map_rd_q;
          commit_kind = lrbc_pkg::KIND_VAR;
          res_load    = 1'b1;
          res_granted = RegW'(map_rd_q);
        end
      end
      lrbc_pkg::ST_PICK: begin
        if (!usable_any) begin
          res_load = 1'b1;
          res_none = 1'b1;
        end else if (free_found) begin
          commit_en   = 1'b1;
          res_load    = 1'b1;
          res_granted = RegW'(free_idx);
          res_fill    = is_bind && load_q;
        end else begin
          search_go = 1'b1;
        end
      end
      lrbc_pkg::ST_SEARCH: owner_raddr = best_idx;
      lrbc_pkg::ST_VICTIM: begin
        commit_en   = 1'b1;
        commit_idx  = best_idx;
        res_load    = 1'b1;
        res_granted = RegW'(best_idx);
        res_fill    = is_bind && load_q;
        if (kind_q[best_idx] == lrbc_pkg::KIND_VAR) begin
          res_spill = 1'b1;
          res_var   = owner_rd_q;
        end
      end
      lrbc_pkg::ST_RELEASE: begin
        res_load    = 1'b1;
        res_granted = rel_q;
        rel_clear   = rel_ok;
        if (rel_ok && (kind_q[rel_q[RegIdxW-1:0]] == lrbc_pkg::KIND_VAR)) begin
          res_spill = 1'b1;
          res_var   = owner_rd_q;
        end
      end
      default: res_load = 1'b0;
    endcase
  end

  // Request fields are held for the whole request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      var_q  <= var_index_i;
      load_q <= load_flag_i;
      rel_q  <= release_reg_i;
    end
  end

  // Register kinds, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegsEff; r++) begin
        kind_q[r] <= lrbc_pkg::KIND_FREE;
      end
    end else if (commit_en) begin
      kind_q[commit_idx] <= commit_kind;
    end else if (rel_clear) begin
      kind_q[rel_q[RegIdxW-1:0]] <= lrbc_pkg::KIND_FREE;
    end
  end

  // Stamp counter advances once per new binding, refresh or temporary.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
    end else if (commit_en) begin
      counter_q <= counter_q + 32'd1;
    end
  end

  // Variable to register map, cleared once after reset and read once when a
  // request is taken.
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      map_mem[clr_q] <= '0;
    end else if (commit_en && is_bind) begin
      map_mem[var_q[VarIdxW-1:0]] <= commit_idx;
    end
    if (accept) begin
      map_rd_q <= map_mem[var_index_i[VarIdxW-1:0]];
    end
  end

  // Owner variable of each register.
  always_ff @(posedge clk_i) begin
    if (commit_en && is_bind) begin
      owner_mem[commit_idx] <= var_q;
    end
    owner_rd_q <= owner_mem[owner_raddr];
  end

  // Least recently used search over the usable registers.
  lrbc_victim_search #(
    .NUM_REGS (NumRegsEff)
  ) u_victim_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (search_go),
    .usable_i   (usable),
    .wr_en_i    (commit_en),
    .wr_idx_i   (commit_idx),
    .wr_stamp_i (counter_q),
    .done_o     (search_done),
    .best_idx_o (best_idx)
  );

  // Result register, shown for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      granted_q     <= res_granted;
      spill_q       <= res_spill;
      spilled_var_q <= res_var;
      fill_q        <= res_fill;
      none_q        <= res_none;
    end
  end

  assign done_o        = done_q;
  assign granted_reg_o = granted_q;
  assign spill_valid_o = spill_q;
  assign spilled_var_o = spilled_var_q;
  assign fill_valid_o  = fill_q;
  assign no_register_o = none_q;

endmodule

@@ design/lrbc_checker.sv @@
// Port checker for the register binding cache and its bind statement.
`timescale 1ns / 1ps

module lrbc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [lrbc_pkg::CmdW-1:0]  command_i,
  input logic                       done_o,
  input logic [lrbc_pkg::RegW-1:0]  granted_reg_o,
  input logic                       spill_valid_o,
  input logic [lrbc_pkg::VarW-1:0]  spilled_var_o,
  input logic                       fill_valid_o,
  input logic                       no_register_o
);

  // A refused request reports nothing else.
  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && no_register_o) |->
      (granted_reg_o == '0) && !spill_valid_o && !fill_valid_o)
    else $error("refused request carries a grant, spill or fill");

  // The spilled variable reads zero when there is no spill.
  a_spill_var_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !spill_valid_o) |-> (spilled_var_o == '0))
    else $error("spilled variable set without a spill");

  // A temporary request, once taken, always makes the block busy.
  a_temp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == lrbc_pkg::CMD_TEMP)) |=> busy)
    else $error("temporary request did not occupy the block");

  // A result only follows a request in progress or one just taken.
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result without a request");

endmodule

bind lru_register_binding_cache_unit lrbc_checker u_lrbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .command_i     (command_i),
  .done_o        (done_o),
  .granted_reg_o (granted_reg_o),
  .spill_valid_o (spill_valid_o),
  .spilled_var_o (spilled_var_o),
  .fill_valid_o  (fill_valid_o),
  .no_register_o (no_register_o)
);
